FILE: rtl/core/mbps_pkg.sv
// ----------------------------------------------------------------------------
// mbps_pkg : shared types and constants of the masked byte pattern scanner
// Word formats, register indexes and the aligned pattern bundle that the
// aligner hands to the window cells.
// ----------------------------------------------------------------------------
package mbps_pkg;

   localparam int MaxPattern    = 16;
   localparam int LenBits       = 5;
   localparam int WinIdxBits    = 4;
   localparam int OffsetBits    = 32;
   localparam int RspOffsetBits = 32;
   localparam int CsrIndexBits  = 2;
   localparam int CsrDataBits   = 64;
   localparam int PatternBits   = 8 * MaxPattern;

   typedef enum logic [CsrIndexBits-1:0] {
      CSR_PATTERN_LOW  = 2'd0,
      CSR_PATTERN_HIGH = 2'd1,
      CSR_CARE_MASK    = 2'd2,
      CSR_PATTERN_LEN  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic                     found;
      logic [RspOffsetBits-1:0] match_offset;
   } rsp_type;

   // Pattern as seen from the window: entry k of bytes/care lines up with
   // window cell k (cell 0 holds the newest byte).
   typedef struct packed {
      logic [LenBits-1:0]               len;
      logic [MaxPattern-1:0]            care;
      logic [MaxPattern-1:0][7:0]       bytes;
   } align_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctl_type;

endpackage

FILE: rtl/core/mbps_align.sv
// ----------------------------------------------------------------------------
// mbps_align : pattern aligner
// Clamps the pattern length and maps pattern byte len-1-k onto window cell k,
// masking care bits of cells outside the pattern.
// ----------------------------------------------------------------------------
module mbps_align (
   input  logic [mbps_pkg::PatternBits-1:0] pattern,
   input  logic [mbps_pkg::MaxPattern-1:0]  care_mask,
   input  logic [mbps_pkg::LenBits-1:0]     pattern_length,
   output mbps_pkg::align_type              aligned
);
   import mbps_pkg::*;

   logic [LenBits-1:0] len_eff;

   always_comb begin
      logic [LenBits-1:0]    j;
      logic [WinIdxBits-1:0] jw;
      if (pattern_length > LenBits'(MaxPattern)) begin
         len_eff = LenBits'(MaxPattern);
      end else begin
         len_eff = pattern_length;
      end
      aligned.len = len_eff;
      for (int k = 0; k < MaxPattern; k++) begin
         j  = len_eff - LenBits'(1) - LenBits'(k);
         jw = j[WinIdxBits-1:0];
         aligned.bytes[k] = pattern[8*jw +: 8];
         aligned.care[k]  = care_mask[jw] & (LenBits'(k) < len_eff);
      end
   end

endmodule

FILE: rtl/core/mbps_cell.sv
// ----------------------------------------------------------------------------
// mbps_cell : one window cell
// Holds one byte of the window, passes it on to the next cell on each word
// and flags whether the byte entering it meets its pattern byte.
// ----------------------------------------------------------------------------
module mbps_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  mbps_pkg::cell_ctl_type ctl,
   input  logic [7:0]             byte_in,
   input  logic [7:0]             pat_byte,
   input  logic                   care,
   output logic [7:0]             byte_out,
   output logic                   hit
);
   import mbps_pkg::*;

   logic [7:0] window_ff;
   logic [7:0] window_in;

   // compare against the byte that lands here on this word
   assign hit       = ~care | (byte_in == pat_byte);
   assign window_in = ctl.clear ? 8'd0 : byte_in;
   assign byte_out  = window_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= 8'd0;
      end else if (ctl.shift) begin
         window_ff <= window_in;
      end
   end

endmodule

FILE: rtl/core/masked_byte_pattern_scanner.sv
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner : wildcard byte signature scan
//
//   channel | direction | handshake            | word
//   req_    | in        | req_valid/req_stall  | data_byte, last_byte
//   rsp_    | out       | rsp_valid/rsp_stall  | found, match_offset
//   csr_    | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// One input word per cycle while req_stall is low: the window shifts through
// a chain of sixteen cells and all masked compares resolve in the cycle the
// byte arrives; the result is registered in the output or skid register.
// A skid register behind the output register keeps input flowing while a
// result is stalled; req_stall rises only while the skid register is full.
// Synchronous reset clears window, counter, done flag, CSRs and valid flags.
// csr_ready is always high.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  mbps_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output mbps_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mbps_pkg::CsrIndexBits-1:0]   csr_index,
   input  logic [mbps_pkg::CsrDataBits-1:0]    csr_data
);
   import mbps_pkg::*;

   logic [63:0]            pat_low_ff;
   logic [63:0]            pat_high_ff;
   logic [MaxPattern-1:0]  care_ff;
   logic [LenBits-1:0]     len_ff;

   logic [OffsetBits-1:0]  bytes_seen_ff;
   logic [OffsetBits-1:0]  bytes_seen_in;
   logic                   done_ff;
   logic                   done_in;

   logic                   out_valid_ff;
   rsp_type                out_data_ff;
   logic                   skid_valid_ff;
   rsp_type                skid_data_ff;

   align_type              aligned;
   cell_ctl_type           ctl;
   logic [MaxPattern-1:0][7:0] cell_byte;
   logic [MaxPattern-1:0]  cell_hit;

   logic                   accept;
   logic                   out_take;
   logic [OffsetBits:0]    idx_plus;
   logic [OffsetBits:0]    offset_full;
   logic                   enough;
   logic                   hit;
   logic                   new_valid;
   rsp_type                new_data;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= 64'd0;
         pat_high_ff <= 64'd0;
         care_ff     <= '0;
         len_ff      <= '0;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_PATTERN_LOW:  pat_low_ff  <= csr_data[63:0];
            CSR_PATTERN_HIGH: pat_high_ff <= csr_data[63:0];
            CSR_CARE_MASK:    care_ff     <= csr_data[MaxPattern-1:0];
            CSR_PATTERN_LEN:  len_ff      <= csr_data[LenBits-1:0];
            default: ;
         endcase
      end
   end

   mbps_align u_align (
      .pattern        ({pat_high_ff, pat_low_ff}),
      .care_mask      (care_ff),
      .pattern_length (len_ff),
      .aligned        (aligned)
   );

   // window chain
   assign accept    = req_valid & ~req_stall;
   assign ctl.shift = accept;
   assign ctl.clear = req_data.last_byte;

   for (genvar k = 0; k < MaxPattern; k++) begin : g_cell
      logic [7:0] byte_in;
      if (k == 0) begin : g_head
         assign byte_in = req_data.data_byte;
      end else begin : g_link
         assign byte_in = cell_byte[k-1];
      end
      mbps_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .byte_in  (byte_in),
         .pat_byte (aligned.bytes[k]),
         .care     (aligned.care[k]),
         .byte_out (cell_byte[k]),
         .hit      (cell_hit[k])
      );
   end

   // match decision
   assign idx_plus    = {1'b0, bytes_seen_ff} + (OffsetBits+1)'(1);
   assign enough      = idx_plus >= (OffsetBits+1)'(aligned.len);
   assign hit         = (aligned.len == '0) | (enough & (&cell_hit));
   assign offset_full = (aligned.len == '0) ? '0
                                            : idx_plus - (OffsetBits+1)'(aligned.len);
   assign new_valid   = accept & ~done_ff & (hit | req_data.last_byte);
   assign new_data.found        = hit;
   assign new_data.match_offset = hit ? RspOffsetBits'(offset_full) : '0;

   always_comb begin
      bytes_seen_in = bytes_seen_ff;
      done_in       = done_ff;
      if (accept) begin
         if (req_data.last_byte) begin
            bytes_seen_in = '0;
            done_in       = 1'b0;
         end else begin
            // saturate
            if (bytes_seen_ff != '1) begin
               bytes_seen_in = bytes_seen_ff + OffsetBits'(1);
            end
            if (hit) begin
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff <= '0;
         done_ff       <= 1'b0;
      end else begin
         bytes_seen_ff <= bytes_seen_in;
         done_ff       <= done_in;
      end
   end

   // output register with skid
   assign out_take  = out_valid_ff & ~rsp_stall;
   assign req_stall = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_take) begin
            out_valid_ff  <= 1'b1;
            out_data_ff   <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (~out_valid_ff | out_take) begin
         out_valid_ff <= new_valid;
         out_data_ff  <= new_data;
      end else if (new_valid) begin
         // hold the new word until the output drains
         skid_valid_ff <= 1'b1;
         skid_data_ff  <= new_data;
      end
   end

endmodule
